FILE: hw/rtl/sbct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Commutation timing core package
// Shared types and codes for the sensorless commutation timing core.
// ----------------------------------------------------------------------------
package sbct_pkg;

  typedef enum logic [1:0] {
    FUNC_OVERFLOW = 2'd0,
    FUNC_CAPTURE  = 2'd1,
    FUNC_TICK     = 2'd2,
    FUNC_SETUP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    TA_NONE = 2'd0,
    TA_LOAD = 2'd1,
    TA_ADD  = 2'd2
  } timer_action_e;

  typedef enum logic [3:0] {
    REG_STARTUP_TIME     = 4'd0,
    REG_BLANK_TICKS      = 4'd1,
    REG_LEAD_TICKS       = 4'd2,
    REG_LEAD_OFFSET      = 4'd3,
    REG_ERROR_SHIFT      = 4'd4,
    REG_GOOD_CROSSINGS   = 4'd5,
    REG_DWELL_TICKS      = 4'd6,
    REG_ALIGN_STEPS      = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] capture_time;
    logic        detect_phase;
    logic        flyback_settled;
  } evt_t;

  typedef struct packed {
    logic        commutate_now;
    logic [1:0]  timer_action;
    logic [15:0] timer_value;
    logic        comparator_enable;
    logic        closed_loop;
    logic        stall_clear;
    logic        align_done;
    logic        timer_enable;
  } res_t;

  typedef struct packed {
    logic [3:0]  reg_index;
    logic [15:0] reg_data;
  } cfg_req_t;

  typedef struct packed {
    logic [15:0] startup_time;
    logic [7:0]  blank_ticks;
    logic [15:0] lead_ticks;
    logic [15:0] lead_offset;
    logic [3:0]  error_shift;
    logic [7:0]  good_crossings_needed;
    logic [7:0]  dwell_ticks;
    logic [7:0]  align_steps;
  } cfg_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sbct_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Commutation timing core channels
// Valid/ready channels for events, results and register writes.
// ----------------------------------------------------------------------------
interface sbct_evt_if;
  import sbct_pkg::*;
  logic valid;
  logic ready;
  evt_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sbct_res_if;
  import sbct_pkg::*;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sbct_cfg_if;
  import sbct_pkg::*;
  logic     valid;
  logic     ready;
  cfg_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sbct_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Commutation timing configuration registers
// Holds the eight configuration registers, written one request at a time.
// ----------------------------------------------------------------------------
module sbct_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  sbct_pkg::cfg_req_t  wr_req_i,
  output sbct_pkg::cfg_t      cfg_o
);
  import sbct_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (reg_idx_e'(wr_req_i.reg_index))
        REG_STARTUP_TIME:   cfg_d.startup_time          = wr_req_i.reg_data;
        REG_BLANK_TICKS:    cfg_d.blank_ticks           = wr_req_i.reg_data[7:0];
        REG_LEAD_TICKS:     cfg_d.lead_ticks            = wr_req_i.reg_data;
        REG_LEAD_OFFSET:    cfg_d.lead_offset           = wr_req_i.reg_data;
        REG_ERROR_SHIFT:    cfg_d.error_shift           = wr_req_i.reg_data[3:0];
        REG_GOOD_CROSSINGS: cfg_d.good_crossings_needed = wr_req_i.reg_data[7:0];
        REG_DWELL_TICKS:    cfg_d.dwell_ticks           = wr_req_i.reg_data[7:0];
        REG_ALIGN_STEPS:    cfg_d.align_steps           = wr_req_i.reg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.startup_time          <= 16'hF000;
      cfg_q.blank_ticks           <= 8'd16;
      cfg_q.lead_ticks            <= 16'd0;
      cfg_q.lead_offset           <= 16'd0;
      cfg_q.error_shift           <= 4'd1;
      cfg_q.good_crossings_needed <= 8'd6;
      cfg_q.dwell_ticks           <= 8'd50;
      cfg_q.align_steps           <= 8'd6;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: hw/rtl/sbct_event_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Commutation timing event core
// Loop state and the combinational handling of one motor event.
// ----------------------------------------------------------------------------
module sbct_event_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  sbct_pkg::evt_t  evt_i,
  input  sbct_pkg::cfg_t  cfg_i,
  output sbct_pkg::res_t  res_o
);
  import sbct_pkg::*;

  logic        await_d, await_q;
  logic        closed_d, closed_q;
  logic        running_d, running_q;
  logic [15:0] period_d, period_q;
  logic [15:0] avg_d, avg_q;
  logic [15:0] half_d, half_q;
  logic [15:0] acp_d, acp_q;
  logic [7:0]  good_d, good_q;
  logic [7:0]  dwell_d, dwell_q;
  logic [7:0]  steps_d, steps_q;

  logic [15:0] period_adj;
  logic [7:0]  good_adj;
  logic [7:0]  good_dec;
  logic [15:0] half_new;
  logic [15:0] err;
  logic [16:0] err_mag;
  logic [15:0] win_neg;
  logic [15:0] win;
  logic        in_window;
  logic [15:0] err_shifted;
  logic [15:0] period_corr;
  logic [15:0] avg_half;
  logic [15:0] cap_half;
  logic [7:0]  dwell_dec;
  logic [7:0]  steps_dec;

  always_comb begin
    period_adj  = (await_q && closed_q) ? period_q - {4'd0, half_q[15:4]} : period_q;
    good_adj    = await_q ? cfg_i.good_crossings_needed : good_q;
    good_dec    = good_adj - 8'd1;
    half_new    = {1'b1, period_adj[15:1]};
    err         = avg_q - half_new;
    err_mag     = err[15] ? 17'h10000 - {1'b0, err} : {1'b0, err};
    win_neg     = 16'd0 - half_new;
    win         = 16'($signed(win_neg) >>> 1);
    in_window   = !win[15] && (err_mag < {2'd0, win[14:0]});
    err_shifted = 16'($signed(err) >>> cfg_i.error_shift);
    period_corr = period_adj - err_shifted;
    avg_half    = {1'b1, avg_q[15:1]};
    cap_half    = {1'b1, evt_i.capture_time[15:1]};
    dwell_dec   = dwell_q - 8'd1;
    steps_dec   = steps_q - 8'd1;
  end

  always_comb begin
    await_d   = await_q;
    closed_d  = closed_q;
    running_d = running_q;
    period_d  = period_q;
    avg_d     = avg_q;
    half_d    = half_q;
    acp_d     = acp_q;
    good_d    = good_q;
    dwell_d   = dwell_q;
    steps_d   = steps_q;

    res_o                   = '0;
    res_o.timer_action      = TA_NONE;

    unique case (func_e'(evt_i.func))
      FUNC_OVERFLOW: begin
        if (running_q) begin
          res_o.commutate_now = 1'b1;
          period_d = period_adj;
          good_d   = good_adj;
          if (evt_i.detect_phase) begin
            res_o.timer_action = TA_ADD;
            res_o.timer_value  = period_adj + {8'd0, cfg_i.blank_ticks};
            if (evt_i.flyback_settled) begin
              res_o.comparator_enable = 1'b1;
              await_d = 1'b1;
            end
          end else begin
            half_d = half_new;
            if (in_window) begin
              res_o.stall_clear = 1'b1;
              if (!closed_q) begin
                good_d = good_dec;
                if (good_dec == 8'd0) begin
                  closed_d = 1'b1;
                end
              end
            end else begin
              good_d = cfg_i.good_crossings_needed;
            end
            period_d = period_corr;
            if (avg_q < period_corr) begin
              avg_d = period_corr;
            end
            res_o.timer_action = TA_ADD;
            res_o.timer_value  = period_corr + cfg_i.lead_offset;
            await_d = 1'b0;
            acp_d   = half_new + cfg_i.lead_ticks;
          end
        end
      end
      FUNC_CAPTURE: begin
        if (await_q) begin
          if (avg_q <= period_q) begin
            avg_d = evt_i.capture_time;
          end else begin
            avg_d = avg_half + cap_half;
          end
          if (closed_q) begin
            res_o.timer_action = TA_LOAD;
            res_o.timer_value  = acp_q;
          end
          await_d = 1'b0;
        end
      end
      FUNC_TICK: begin
        dwell_d = dwell_dec;
        if (dwell_dec == 8'd0) begin
          steps_d = steps_dec;
          dwell_d = cfg_i.dwell_ticks;
          if (steps_dec == 8'd0) begin
            good_d    = cfg_i.good_crossings_needed;
            period_d  = cfg_i.startup_time;
            half_d    = {1'b1, cfg_i.startup_time[15:1]};
            avg_d     = cfg_i.startup_time;
            acp_d     = {1'b1, cfg_i.startup_time[15:1]};
            await_d   = 1'b0;
            running_d = 1'b1;
            res_o.timer_action = TA_LOAD;
            res_o.timer_value  = cfg_i.startup_time;
            res_o.align_done   = 1'b1;
          end else begin
            res_o.commutate_now = 1'b1;
          end
        end
      end
      FUNC_SETUP: begin
        dwell_d = cfg_i.dwell_ticks;
        steps_d = cfg_i.align_steps;
        res_o.commutate_now = 1'b1;
      end
      default: ;
    endcase

    res_o.closed_loop  = closed_d;
    res_o.timer_enable = running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q   <= 1'b0;
      closed_q  <= 1'b0;
      running_q <= 1'b0;
      period_q  <= 16'd0;
      avg_q     <= 16'd0;
      half_q    <= 16'd0;
      acp_q     <= 16'd0;
      good_q    <= 8'd0;
      dwell_q   <= 8'd0;
      steps_q   <= 8'd0;
    end else if (accept_i) begin
      await_q   <= await_d;
      closed_q  <= closed_d;
      running_q <= running_d;
      period_q  <= period_d;
      avg_q     <= avg_d;
      half_q    <= half_d;
      acp_q     <= acp_d;
      good_q    <= good_d;
      dwell_q   <= dwell_d;
      steps_q   <= steps_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sensorless_bldc_commutation_timing_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensorless commutation timing core
// Event-driven commutation timer for a sensorless three-phase motor drive.
//
// Events (timer overflow, zero-cross capture, alignment tick, setup) arrive
// as requests on in_i; each one yields exactly one result request on out_o.
// Registers are written through cfg_i, which is always ready; write them only
// while no event is in flight.
// A result appears in the cycle after its event is accepted. The loop state and
// the output register are updated in the same cycle, so one event is
// accepted every cycle while the output is free or being taken.
// When the receiver stalls, the pending result holds in the output register
// and in_i drops ready until it is taken.
// Reset clears the loop state, loads the register defaults and empties the
// output register.
// ----------------------------------------------------------------------------
module sensorless_bldc_commutation_timing_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  sbct_evt_if.sink   in_i,
  sbct_res_if.source out_o,
  sbct_cfg_if.sink   cfg_i
);
  import sbct_pkg::*;

  cfg_t cfg;
  res_t res;
  logic accept;
  logic out_valid_d, out_valid_q;
  res_t out_data_q;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;

  sbct_cfg_regs u_cfg_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cfg_i.valid),
    .wr_req_i (cfg_i.payload),
    .cfg_o    (cfg)
  );

  sbct_event_core u_event_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .evt_i    (in_i.payload),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  assign out_valid_d = accept || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

endmodule
`default_nettype wire
